FILE: sv/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg: shared definitions for the radix integer-to-ASCII converter
// Holds the controller state type, character codes, field widths and defaults.
// ----------------------------------------------------------------------------
package itoa_pkg;

  // Default sizes handed to the top level.
  localparam int unsigned VALUE_WIDTH_DEF = 64;
  localparam int unsigned DIGIT_SLOTS_DEF = 64;

  // Fixed field widths.
  localparam int unsigned VALUE_IN_W = 64;
  localparam int unsigned RADIX_W    = 6;
  localparam int unsigned DIGIT_W    = 5;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned LEN_W      = 7;
  localparam int unsigned S_TDATA_W  = 72;
  localparam int unsigned M_TDATA_W  = 16;
  localparam int unsigned SIGNED_W   = 32;

  // Radix limits.
  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd32;
  localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;

  // Mode codes carried in the slave tuser bit.
  localparam logic CMD_UNSIGNED = 1'b0;
  localparam logic CMD_SIGNED   = 1'b1;

  // ASCII codes.
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_A     = 8'd65;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_LOAD,
    ST_OUT
  } itoa_state_e;

  // Maps one digit value to its character.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dw;
    dw = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d >= 5'd10) begin
      digit_char = CHAR_A + dw - 8'd10;
    end else begin
      digit_char = CHAR_ZERO + dw;
    end
  endfunction

endpackage

FILE: sv/radix_integer_to_ascii_core.sv
// ----------------------------------------------------------------------------
// radix_integer_to_ascii_core: integer to ASCII text in radix 2 to 32
// Converts one integer per transaction into a stream of characters, most
// significant digit first, using a bit-serial shift-subtract divider.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Fields (tdata from bit 0 up)             tuser   tlast
//  -------  ---  ---------------------------------------  ------  ------------
//  s_axis   in   value_in[63:0], radix[69:64], pad [71:70] cmd     (none)
//  m_axis   out  char_out[7:0], length[14:8], pad [15]     error   last
//
//  The divider produces one quotient bit per cycle and runs a full
//  VALUE_WIDTH-bit division for every digit. Each emitted digit then passes
//  through the digit store read, output load and handoff states; a sign is
//  handed off before the digits. After the final character the block returns
//  to idle, in which the next request can be accepted. A bad radix produces
//  its single error transaction in the cycle after accept.
//  Reset clears the controller and counters; the digit store is not cleared,
//  as every entry is written before it is read. A stall on m_axis holds the
//  current character; s_axis is ready only while no conversion is in flight.
//
module radix_integer_to_ascii_core
  import itoa_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int unsigned DIGIT_SLOTS = DIGIT_SLOTS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // value_in [63:0], radix [69:64], zero pad [71:70]
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // cmd [0]
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // char_out [7:0], length [14:8], zero pad [15]
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // error [0]
  output logic                 m_axis_tuser,
  output logic                 m_axis_tlast
);

  localparam int unsigned BW = $clog2(VALUE_WIDTH);
  localparam int unsigned AW = $clog2(DIGIT_SLOTS);
  localparam int unsigned CW = $clog2(DIGIT_SLOTS + 1);

  itoa_state_e state_q, state_d;

  // Divider: quotient shifts left one bit per cycle, remainder collects bits.
  logic [VALUE_WIDTH-1:0] quot_q;
  logic [DIGIT_W-1:0]     rem_q;
  logic [RADIX_W-1:0]     radix_q;
  logic [BW-1:0]          bit_q;
  logic                   neg_q;

  // Digit store bookkeeping. The store is circular, so once it fills the
  // newest digits overwrite the oldest ones.
  logic [AW-1:0] wptr_q;
  logic [AW-1:0] rptr_q;
  logic [CW-1:0] cnt_q;
  logic [CW-1:0] left_q;

  logic [DIGIT_W-1:0] digit_mem [DIGIT_SLOTS];
  logic [DIGIT_W-1:0] rd_data_q;

  // Output register.
  logic [CHAR_W-1:0] out_char_q;
  logic [LEN_W-1:0]  out_len_q;
  logic              out_last_q;
  logic              out_err_q;

  // Handshakes and decoded input fields.
  logic                  s_hs;
  logic                  m_hs;
  logic [VALUE_IN_W-1:0] in_value;
  logic [RADIX_W-1:0]    in_radix;
  logic                  radix_ok;
  logic [SIGNED_W-1:0]   in_low;
  logic [SIGNED_W-1:0]   in_mag;
  logic [VALUE_WIDTH-1:0] start_quot;
  logic                  start_neg;

  // One divider step.
  logic [DIGIT_W:0]       trial;
  logic                   trial_ge;
  logic [DIGIT_W-1:0]     rem_nxt;
  logic [VALUE_WIDTH-1:0] quot_nxt;
  logic                   digit_done;
  logic                   quot_zero;

  logic [AW-1:0] wptr_inc;
  logic [AW-1:0] rptr_dec;
  logic [CW-1:0] cnt_nxt;
  logic [LEN_W-1:0] len_total;

  // Controls from the output decoder.
  logic mem_we;
  logic mem_re;

  assign s_hs = s_axis_tvalid && s_axis_tready;
  assign m_hs = m_axis_tvalid && m_axis_tready;

  assign in_value = s_axis_tdata[VALUE_IN_W-1:0];
  assign in_radix = s_axis_tdata[VALUE_IN_W +: RADIX_W];
  assign radix_ok = (in_radix >= RADIX_MIN) && (in_radix <= RADIX_MAX);

  // Signed mode: magnitude of the low 32 bits; the most negative value
  // yields 2^31, which the 32-bit negation gives naturally.
  assign in_low = in_value[SIGNED_W-1:0];
  assign in_mag = in_low[SIGNED_W-1] ? (~in_low + 1'b1) : in_low;

  always_comb begin
    if (s_axis_tuser == CMD_SIGNED) begin
      start_quot = VALUE_WIDTH'(in_mag);
    end else begin
      start_quot = in_value[VALUE_WIDTH-1:0];
    end
  end

  // The minus sign is printed for negative values in base ten only.
  assign start_neg = (s_axis_tuser == CMD_SIGNED) && in_low[SIGNED_W-1] &&
                     (in_radix == RADIX_DEC);

  // Restoring division step. The remainder stays below the radix, at most 31,
  // so the trial value fits six bits and the difference fits five.
  assign trial    = {rem_q, quot_q[VALUE_WIDTH-1]};
  assign trial_ge = (trial >= radix_q);
  assign rem_nxt  = trial_ge ? DIGIT_W'(trial - radix_q) : trial[DIGIT_W-1:0];
  assign quot_nxt = {quot_q[VALUE_WIDTH-2:0], trial_ge};

  assign digit_done = (bit_q == '0);
  assign quot_zero  = (quot_nxt == '0);

  assign wptr_inc = (wptr_q == AW'(DIGIT_SLOTS - 1)) ? '0 : wptr_q + 1'b1;
  assign rptr_dec = (rptr_q == '0) ? AW'(DIGIT_SLOTS - 1) : rptr_q - 1'b1;
  assign cnt_nxt  = (cnt_q < CW'(DIGIT_SLOTS)) ? cnt_q + 1'b1 : cnt_q;

  assign len_total = LEN_W'(cnt_q) + LEN_W'(neg_q);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_hs) begin
          state_d = radix_ok ? ST_DIV : ST_OUT;
        end
      end
      ST_DIV: begin
        if (digit_done && quot_zero) begin
          state_d = neg_q ? ST_OUT : ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (m_hs) begin
          state_d = out_last_q ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output and control decode.
  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      ST_DIV: begin
        mem_we = digit_done;
      end
      ST_READ: begin
        mem_re = 1'b1;
      end
      ST_LOAD: begin
      end
      ST_OUT: begin
        m_axis_tvalid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Divider and digit bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quot_q <= '0;
      bit_q  <= '0;
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
      left_q <= '0;
      neg_q  <= 1'b0;
    end else begin
      if (s_hs) begin
        quot_q <= start_quot;
        bit_q  <= BW'(VALUE_WIDTH - 1);
        wptr_q <= '0;
        cnt_q  <= '0;
        neg_q  <= start_neg;
      end else if (state_q == ST_DIV) begin
        quot_q <= quot_nxt;
        // The bit counter restarts at the top bit for every digit.
        bit_q  <= digit_done ? BW'(VALUE_WIDTH - 1) : bit_q - 1'b1;
        if (digit_done) begin
          // The next digit restarts the divider on the fresh quotient.
          wptr_q <= wptr_inc;
          cnt_q  <= cnt_nxt;
          rptr_q <= wptr_q;
          left_q <= cnt_nxt;
        end
      end else if (state_q == ST_READ) begin
        rptr_q <= rptr_dec;
        left_q <= left_q - 1'b1;
      end
    end
  end

  // Payload registers of the divider need no reset.
  always_ff @(posedge clk_i) begin
    if (s_hs) begin
      rem_q   <= '0;
      radix_q <= in_radix;
    end else if (state_q == ST_DIV) begin
      rem_q <= digit_done ? '0 : rem_nxt;
    end
  end

  // Digit store, one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      digit_mem[wptr_q] <= rem_nxt;
    end
    if (mem_re) begin
      rd_data_q <= digit_mem[rptr_q];
    end
  end

  // Output register: error result, minus sign or one digit character.
  always_ff @(posedge clk_i) begin
    if (s_hs && !radix_ok) begin
      out_char_q <= CHAR_NONE;
      out_last_q <= 1'b1;
      out_err_q  <= 1'b1;
      out_len_q  <= '0;
    end else if (state_q == ST_DIV && digit_done && quot_zero) begin
      // Only the sign is loaded here; digits go through the store read.
      out_char_q <= CHAR_MINUS;
      out_last_q <= 1'b0;
      out_err_q  <= 1'b0;
      out_len_q  <= '0;
    end else if (state_q == ST_LOAD) begin
      out_char_q <= digit_char(rd_data_q);
      out_last_q <= (left_q == '0);
      out_err_q  <= 1'b0;
      out_len_q  <= (left_q == '0) ? len_total : '0;
    end
  end

  assign m_axis_tdata = {1'b0, out_len_q, out_char_q};
  assign m_axis_tuser = out_err_q;
  assign m_axis_tlast = out_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // An error result is always a single, final, empty transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |->
      (m_axis_tlast && m_axis_tdata[7:0] == CHAR_NONE && m_axis_tdata[14:8] == '0))
    else $error("error result is not a lone final transaction");

  // Input is never taken while a result is still being offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input accepted during output");

  // The digit count saturates at the store depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DIGIT_SLOTS))
    else $error("digit count beyond store depth");

  // After the final character the block is ready for the next conversion.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_hs && m_axis_tlast) |=> s_axis_tready)
    else $error("block not idle after final character");

endmodule
